// File: rtl/eg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ElGamal unit package
// Shared widths, payload structs, register indexes and control structs.
// ----------------------------------------------------------------------------
package eg_pkg;

    localparam int WIDTH_DEF = 32;
    localparam int FW        = 32;

    localparam logic [1:0] REG_MODULUS   = 2'd0;
    localparam logic [1:0] REG_GENERATOR = 2'd1;
    localparam logic [1:0] REG_PRIV_KEY  = 2'd2;

    typedef struct packed {
        logic [FW-1:0] message;
        logic [FW-1:0] nonce;
    } eg_in_t;

    typedef struct packed {
        logic [FW-1:0] public_key;
        logic [FW-1:0] cipher_first;
        logic [FW-1:0] cipher_second;
        logic [FW-1:0] recovered_message;
        logic          inverse_found;
    } eg_out_t;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE   = 4'd0,
        OP_LOAD   = 4'd1,  // latch inputs, reduce operands
        OP_PINIT  = 4'd2,  // start power: acc=1, b=base, e=exp (sel)
        OP_PSTEP  = 4'd3,  // start one multiply of a square-and-multiply round
        OP_PSAVE  = 4'd4,  // store a power step product (by phase)
        OP_MUL    = 4'd5,  // start modular multiply x*y (sel)
        OP_MSAVE  = 4'd6,  // store a result register (sel)
        OP_IINIT  = 4'd7,  // start inverse
        OP_DIV    = 4'd8,  // start n1/n2 division
        OP_ISTEP  = 4'd9,  // inverse update after division and multiply
        OP_DONE   = 4'd10
    } eg_op_t;

    typedef struct packed {
        eg_op_t     op;
        logic [2:0] sel;
    } eg_cmd_t;

    typedef struct packed {
        logic busy;      // multiplier or divider running
        logic e_zero;    // exponent exhausted
        logic e_lsb;
        logic r_zero;    // remainder zero
        logic v_zero;    // shared secret zero
        logic p_small;   // modulus below two
        logic n2_one;    // last divisor is one
    } eg_stat_t;

endpackage
`default_nettype wire

// File: rtl/elgamal_encrypt_decrypt_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ElGamal encrypt/decrypt unit
// Computes public key, ciphertext pair and recovered message per beat.
// ----------------------------------------------------------------------------
// Usage:
//   Configure modulus, generator and private key through cfg_we/cfg_index/
//   cfg_data while idle. Send one input beat (message, nonce) on in_valid/
//   in_ready; one result beat follows on out_valid/out_ready.
//   One item at a time: in_ready is high only while idle.
//   Per item: two reductions by the divider, four exponentiations of up to
//   WIDTH rounds, each round two serial modular multiplies, plus an
//   extended Euclid loop of serial divides and multiplies.
//   The multiplier and divider are bit serial.
//   A modulus below two gives an all-zero result beat in the cycle after the item is taken.
//   Reset clears control and loads register defaults (3, 2, 1).
//   A stalled receiver holds the result beat; no new item is taken.
// ----------------------------------------------------------------------------
module elgamal_encrypt_decrypt_unit
    import eg_pkg::*;
#(
    parameter int WIDTH = WIDTH_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [1:0]       cfg_index,
    input  wire logic [WIDTH-1:0] cfg_data,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire eg_in_t           in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output eg_out_t               out_data
);
    logic [WIDTH-1:0] p_reg, g_reg, d_reg;
    eg_cmd_t  cmd;
    eg_stat_t stat;
    eg_out_t  res;
    logic     zero;
    eg_in_t   din;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_reg <= WIDTH'(3);
            g_reg <= WIDTH'(2);
            d_reg <= WIDTH'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MODULUS:   p_reg <= cfg_data;
                REG_GENERATOR: g_reg <= cfg_data;
                REG_PRIV_KEY:  d_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        din.message = FW'(WIDTH'(in_data.message));
        din.nonce   = FW'(WIDTH'(in_data.nonce));
    end

    eg_datapath #(.WIDTH(WIDTH)) u_dp (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (cmd),
        .p    (p_reg),
        .gen  (g_reg),
        .key  (d_reg),
        .din  (din),
        .stat (stat),
        .res  (res)
    );

    eg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .stat     (stat),
        .cmd      (cmd),
        .zero_out (zero)
    );

    assign out_data = zero ? '0 : res;

    a_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid) else $error("in_ready while result pending");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid) else $error("result dropped");
    a_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.inverse_found |-> out_data.recovered_message == '0)
        else $error("recovered value without inverse");

endmodule
`default_nettype wire

// File: rtl/eg_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ElGamal datapath
// Modular multiply (bit serial double-and-add), restoring divider and
// operand registers driven by controller commands.
// ----------------------------------------------------------------------------
module eg_datapath
    import eg_pkg::*;
#(
    parameter int WIDTH = WIDTH_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire eg_cmd_t          cmd,
    input  wire logic [WIDTH-1:0] p,
    input  wire logic [WIDTH-1:0] gen,
    input  wire logic [WIDTH-1:0] key,
    input  wire eg_in_t           din,
    output eg_stat_t              stat,
    output eg_out_t               res
);
    localparam int CW = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] msg_reg, k_reg, pub_reg, c1_reg, c2_reg, s_reg, rec_reg;
    logic [WIDTH-1:0] acc_reg, b_reg, e_reg;
    logic             found_reg;
    // multiplier
    logic [WIDTH-1:0] mx_reg, my_reg, macc_reg;
    logic [CW-1:0]    mcnt_reg;
    logic             mbusy_reg;
    // divider
    logic [WIDTH-1:0] dn_reg, dd_reg, dq_reg, drem_reg;
    logic [CW-1:0]    dcnt_reg;
    logic             dbusy_reg;
    // inverse
    logic [WIDTH-1:0] n1_reg, n2_reg, b1_reg, b2_reg;
    logic [1:0]       ph_reg;  // power sub phase

    function automatic logic [WIDTH-1:0] addm(input logic [WIDTH-1:0] x,
                                              input logic [WIDTH-1:0] y,
                                              input logic [WIDTH-1:0] m);
        logic [WIDTH-1:0] t;
        t = m - y;
        return (x >= t) ? x - t : x + y;
    endfunction

    logic [WIDTH-1:0] dbl, mstep;
    always_comb
    begin
        dbl   = addm(macc_reg, macc_reg, p);
        mstep = my_reg[WIDTH-1] ? addm(dbl, mx_reg, p) : dbl;
    end

    logic [WIDTH:0]   rsh;
    logic             rge;
    always_comb
    begin
        rsh = {drem_reg, dn_reg[WIDTH-1]};
        rge = rsh >= {1'b0, dd_reg};
    end

    // start division helper: reducing value by p uses the divider too
    logic             mstart, dstart;
    logic [WIDTH-1:0] mx_next, my_next, dn_next, dd_next;

    always_comb
    begin
        mstart  = 1'b0;
        dstart  = 1'b0;
        mx_next = acc_reg;
        my_next = b_reg;
        dn_next = n1_reg;
        dd_next = n2_reg;
        case (cmd.op)
            OP_LOAD:
            begin
                dstart = 1'b1;
                dn_next = (cmd.sel == 3'd0) ? WIDTH'(din.message) : gen;
                dd_next = p;
            end
            OP_PSTEP:
            begin
                mstart = 1'b1;
                if (ph_reg == 2'd0)
                begin
                    mx_next = acc_reg;
                    my_next = b_reg;
                end
                else
                begin
                    mx_next = b_reg;
                    my_next = b_reg;
                end
            end
            OP_MUL:
            begin
                mstart = 1'b1;
                case (cmd.sel)
                    3'd0:    begin mx_next = msg_reg; my_next = acc_reg; end
                    3'd1:    begin mx_next = c2_reg;  my_next = b2_reg;  end
                    default: begin mx_next = dq_reg;  my_next = b2_reg;  end
                endcase
            end
            OP_DIV:
            begin
                dstart = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mbusy_reg <= 1'b0;
            dbusy_reg <= 1'b0;
            ph_reg    <= 2'd0;
            found_reg <= 1'b0;
        end
        else
        begin
            if (mstart)
            begin
                mbusy_reg <= 1'b1;
                mx_reg    <= mx_next;
                my_reg    <= my_next;
                macc_reg  <= '0;
                mcnt_reg  <= CW'(WIDTH);
            end
            else if (mbusy_reg)
            begin
                macc_reg <= mstep;
                my_reg   <= my_reg << 1;
                mcnt_reg <= mcnt_reg - 1'b1;
                if (mcnt_reg == CW'(1))
                    mbusy_reg <= 1'b0;
            end
            if (dstart)
            begin
                dbusy_reg <= 1'b1;
                dn_reg    <= dn_next;
                dd_reg    <= dd_next;
                drem_reg  <= '0;
                dcnt_reg  <= CW'(WIDTH);
            end
            else if (dbusy_reg)
            begin
                drem_reg <= rge ? WIDTH'(rsh - {1'b0, dd_reg}) : rsh[WIDTH-1:0];
                dn_reg   <= {dn_reg[WIDTH-2:0], rge};
                dcnt_reg <= dcnt_reg - 1'b1;
                if (dcnt_reg == CW'(1))
                    dbusy_reg <= 1'b0;
            end
            case (cmd.op)
                OP_LOAD:
                begin
                    if (cmd.sel == 3'd0)
                        k_reg <= WIDTH'(din.nonce);
                end
                OP_PINIT:
                begin
                    acc_reg <= WIDTH'(1);
                    ph_reg  <= 2'd0;
                    case (cmd.sel)
                        3'd0:    begin b_reg <= s_reg;   e_reg <= key;   end
                        3'd1:    begin b_reg <= s_reg;   e_reg <= k_reg; end
                        3'd2:    begin b_reg <= pub_reg; e_reg <= k_reg; end
                        default: begin b_reg <= c1_reg;  e_reg <= key;   end
                    endcase
                end
                OP_PSTEP:
                begin
                    ph_reg <= ph_reg + 2'd1;
                end
                OP_PSAVE:
                begin
                    case (ph_reg)
                        2'd1: if (e_reg[0]) acc_reg <= macc_reg;
                        default:
                        begin
                            b_reg <= macc_reg;
                            e_reg <= e_reg >> 1;
                        end
                    endcase
                    if (ph_reg == 2'd2)
                        ph_reg <= 2'd0;
                end
                OP_MSAVE:
                begin
                    case (cmd.sel)
                        3'd0:    msg_reg <= drem_reg;   // reduced message
                        3'd1:    s_reg   <= drem_reg;   // reduced generator
                        3'd2:    pub_reg <= acc_reg;
                        3'd3:    c1_reg  <= acc_reg;
                        3'd4:    c2_reg  <= macc_reg;
                        3'd5:    s_reg   <= acc_reg;
                        default: rec_reg <= macc_reg;
                    endcase
                end
                OP_IINIT:
                begin
                    n1_reg    <= p;
                    n2_reg    <= s_reg;
                    b1_reg    <= '0;
                    b2_reg    <= WIDTH'(1);
                    found_reg <= 1'b0;
                end
                OP_ISTEP:
                begin
                    n1_reg <= n2_reg;
                    n2_reg <= drem_reg;
                    b1_reg <= b2_reg;
                    b2_reg <= (b1_reg >= macc_reg) ? b1_reg - macc_reg
                                                   : p - (macc_reg - b1_reg);
                end
                OP_DONE:
                begin
                    found_reg <= (cmd.sel == 3'd1);
                    if (cmd.sel != 3'd1)
                        rec_reg <= '0;
                end
                default: ;
            endcase
            if (dbusy_reg && dcnt_reg == CW'(1))
                dq_reg <= {dn_reg[WIDTH-2:0], rge};
        end
    end

    always_comb
    begin
        stat.busy    = mbusy_reg | dbusy_reg;
        stat.e_zero  = (e_reg == '0);
        stat.e_lsb   = e_reg[0];
        stat.r_zero  = (drem_reg == '0);
        stat.v_zero  = (s_reg == '0);
        stat.p_small = (p < WIDTH'(2));
        stat.n2_one  = (n2_reg == WIDTH'(1));
        res.public_key        = FW'(pub_reg);
        res.cipher_first      = FW'(c1_reg);
        res.cipher_second     = FW'(c2_reg);
        res.recovered_message = FW'(rec_reg);
        res.inverse_found     = found_reg;
    end

endmodule
`default_nettype wire

// File: rtl/eg_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ElGamal controller
// Sequences reductions, four exponentiations, the inverse and the
// ciphertext and recovery multiplies, then presents the result beat.
// ----------------------------------------------------------------------------
module eg_ctrl
    import eg_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  wire logic     out_ready,
    input  wire eg_stat_t stat,
    output eg_cmd_t       cmd,
    output logic          zero_out
);
    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_RED   = 13'b0000000000010,
        S_WAIT  = 13'b0000000000100,
        S_PINIT = 13'b0000000001000,
        S_PTEST = 13'b0000000010000,
        S_PMUL  = 13'b0000000100000,
        S_PWAIT = 13'b0000001000000,
        S_MUL   = 13'b0000010000000,
        S_MWAIT = 13'b0000100000000,
        S_IINIT = 13'b0001000000000,
        S_DWAIT = 13'b0010000000000,
        S_IMWT  = 13'b0100000000000,
        S_OUT   = 13'b1000000000000
    } st_t;

    st_t        st_reg, st_next;
    logic [3:0] job_reg, job_next;   // step number in the item sequence
    logic [1:0] ph_reg, ph_next;
    logic       zero_reg, zero_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= S_IDLE;
            job_reg  <= '0;
            ph_reg   <= '0;
            zero_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            job_reg  <= job_next;
            ph_reg   <= ph_next;
            zero_reg <= zero_next;
        end
    end

    assign in_ready  = st_reg == S_IDLE;
    assign out_valid = st_reg == S_OUT;
    assign zero_out  = zero_reg;

    // jobs: 0 reduce msg, 1 reduce gen, 2 pub, 3 c1, 4 pub^k and c2,
    //       6 s and inverse, 8 rec
    always_comb
    begin
        st_next   = st_reg;
        job_next  = job_reg;
        ph_next   = ph_reg;
        zero_next = zero_reg;
        cmd.op    = OP_NONE;
        cmd.sel   = 3'd0;
        case (st_reg)
            S_IDLE:
            if (in_valid)
            begin
                zero_next = stat.p_small;
                job_next  = 4'd0;
                cmd.op    = OP_LOAD;
                cmd.sel   = 3'd0;
                st_next   = stat.p_small ? S_OUT : S_WAIT;
            end
            S_RED:
            begin
                cmd.op  = OP_LOAD;
                cmd.sel = 3'd1;
                st_next = S_WAIT;
            end
            S_WAIT:
            if (!stat.busy)
            begin
                cmd.op  = OP_MSAVE;
                cmd.sel = job_reg[2:0];
                job_next = job_reg + 4'd1;
                st_next  = (job_reg == 4'd0) ? S_RED : S_PINIT;
            end
            S_PINIT:
            begin
                cmd.op  = OP_PINIT;
                case (job_reg)
                    4'd2:    cmd.sel = 3'd0;
                    4'd3:    cmd.sel = 3'd1;
                    4'd4:    cmd.sel = 3'd2;
                    default: cmd.sel = 3'd3;
                endcase
                ph_next = 2'd0;
                st_next = S_PTEST;
            end
            S_PTEST:
            if (stat.e_zero)
            begin
                if (job_reg == 4'd4)
                begin
                    st_next = S_MUL;
                end
                else
                begin
                    cmd.op  = OP_MSAVE;
                    case (job_reg)
                        4'd2:    cmd.sel = 3'd2;
                        4'd3:    cmd.sel = 3'd3;
                        default: cmd.sel = 3'd5;
                    endcase
                    job_next = (job_reg == 4'd3) ? 4'd4 : job_reg + 4'd1;
                    st_next  = (job_reg == 4'd6) ? S_IINIT : S_PINIT;
                end
            end
            else
            begin
                cmd.op  = OP_PSTEP;
                st_next = S_PWAIT;
            end
            S_PWAIT:
            if (!stat.busy)
            begin
                cmd.op  = OP_PSAVE;
                ph_next = ph_reg + 2'd1;
                st_next = (ph_reg == 2'd0) ? S_PMUL : S_PTEST;
            end
            S_PMUL:
            begin
                cmd.op  = OP_PSTEP;
                st_next = S_PWAIT;
                ph_next = 2'd1;
            end
            S_MUL:
            begin
                cmd.op  = OP_MUL;
                cmd.sel = (job_reg == 4'd8) ? 3'd1 : 3'd0;
                st_next = S_MWAIT;
            end
            S_MWAIT:
            if (!stat.busy)
            begin
                cmd.op = OP_MSAVE;
                if (job_reg == 4'd8)
                begin
                    cmd.sel = 3'd6;
                    st_next = S_OUT;
                end
                else
                begin
                    cmd.sel  = 3'd4;
                    job_next = 4'd6;
                    st_next  = S_PINIT;
                end
            end
            S_IINIT:
            if (stat.v_zero)
            begin
                cmd.op  = OP_DONE;
                st_next = S_OUT;
            end
            else
            begin
                cmd.op  = OP_IINIT;
                st_next = S_DWAIT;
                ph_next = 2'd0;
            end
            S_DWAIT:
            if (ph_reg == 2'd0)
            begin
                cmd.op  = OP_DIV;
                ph_next = 2'd1;
            end
            else if (!stat.busy)
            begin
                if (stat.r_zero)
                begin
                    cmd.op   = OP_DONE;
                    cmd.sel  = stat.n2_one ? 3'd1 : 3'd0;
                    job_next = 4'd8;
                    st_next  = stat.n2_one ? S_MUL : S_OUT;
                end
                else
                begin
                    cmd.op  = OP_MUL;
                    cmd.sel = 3'd2;
                    st_next = S_IMWT;
                end
            end
            S_IMWT:
            if (!stat.busy)
            begin
                cmd.op  = OP_ISTEP;
                ph_next = 2'd0;
                st_next = S_DWAIT;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    st_next = S_IDLE;
                    ph_next = 2'd0;
                end
            end
            default: st_next = S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

// File: verif/elgamal_encrypt_decrypt_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ElGamal encrypt/decrypt unit testbench
// Writes several key/modulus settings while idle and sends message/nonce
// beats through a queue-fed driver. A monitor predicts the public key,
// the ciphertext pair and the recovered message of every accepted beat
// and checks each result beat against the oldest prediction. Both sides
// idle at random.
// ----------------------------------------------------------------------------
module elgamal_encrypt_decrypt_unit_tb;
    import eg_pkg::*;

    localparam int WD_LIMIT = 200000;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [31:0] cfg_data;
    logic       in_valid;
    logic       in_ready;
    eg_in_t     in_data;
    logic       out_valid;
    logic       out_ready;
    eg_out_t    out_data;

    eg_in_t     msg_q[$];
    eg_out_t    result_q[$];
    logic [31:0] mod_r, gen_r, key_r;
    bit         gaps_on;
    bit         hold_send;
    bit         failed;
    int         send_gap;
    int         recv_gap;
    int         idle_cycles;
    logic       in_ready_seen;
    logic       out_taken;

    elgamal_encrypt_decrypt_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic [63:0] mul_mod(logic [63:0] x, logic [63:0] y, logic [63:0] m);
        return (x * y) % m;
    endfunction

    function automatic logic [63:0] pow_mod(logic [63:0] b, logic [63:0] e, logic [63:0] m);
        logic [63:0] acc;
        acc = 1 % m;
        b = b % m;
        while (e != 0)
        begin
            if (e[0])
                acc = mul_mod(acc, b, m);
            b = mul_mod(b, b, m);
            e = e >> 1;
        end
        return acc;
    endfunction

    function automatic logic [63:0] inv_mod(logic [63:0] v, logic [63:0] m, output bit ok);
        logic [63:0] n1, n2, b1, b2, q, r, t;
        ok = 1'b0;
        if (v == 0)
            return 0;
        n1 = m;
        n2 = v;
        b1 = 0;
        b2 = 1 % m;
        q = n1 / n2;
        r = n1 % n2;
        while (r != 0)
        begin
            n1 = n2;
            n2 = r;
            t = b2;
            b2 = mul_mod(q % m, b2, m);
            b2 = (b1 >= b2) ? (b1 - b2) : (m - (b2 - b1));
            b1 = t;
            q = n1 / n2;
            r = n1 % n2;
        end
        if (n2 == 1)
        begin
            ok = 1'b1;
            return b2;
        end
        return 0;
    endfunction

    function automatic eg_out_t encrypt_roundtrip(eg_in_t item);
        eg_out_t res;
        logic [63:0] p, pub, c1, c2, s, inv, rec;
        bit ok;
        res = '0;
        p = mod_r;
        if (p < 2)
            return res;
        pub = pow_mod(gen_r, key_r, p);
        c1 = pow_mod(gen_r, item.nonce, p);
        c2 = mul_mod(item.message % p, pow_mod(pub, item.nonce, p), p);
        s = pow_mod(c1, key_r, p);
        inv = inv_mod(s, p, ok);
        rec = ok ? mul_mod(c2, inv, p) : 64'd0;
        res.public_key = pub[31:0];
        res.cipher_first = c1[31:0];
        res.cipher_second = c2[31:0];
        res.recovered_message = rec[31:0];
        res.inverse_found = ok;
        return res;
    endfunction

    // driver
    always @(negedge clk)
    begin
        int g;
        if (rst_n)
        begin
            if (in_valid && !(in_valid && in_ready_seen))
            begin
            end
            else if (send_gap > 0)
            begin
                in_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (msg_q.size() > 0 && !hold_send)
            begin
                in_valid <= 1'b1;
                in_data <= msg_q.pop_front();
                send_gap <= gaps_on ? $urandom_range(0, 7) : 0;
            end
            else
                in_valid <= 1'b0;

            if (out_taken)
            begin
                g = gaps_on ? $urandom_range(0, 7) : 0;
                out_ready <= (g == 0);
                recv_gap <= g;
            end
            else if (!out_ready)
            begin
                if (recv_gap > 1)
                    recv_gap <= recv_gap - 1;
                else
                begin
                    out_ready <= 1'b1;
                    recv_gap <= 0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        eg_out_t want;
        in_ready_seen <= in_valid && in_ready;
        out_taken <= out_valid && out_ready;
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (in_valid && in_ready)
            begin
                result_q.push_back(encrypt_roundtrip(in_data));
            end
            if (out_valid && out_ready)
            begin
                if (result_q.size() == 0)
                begin
                    $display("%0t: unexpected result beat %p", $time, out_data);
                    failed = 1'b1;
                end
                else
                begin
                    want = result_q.pop_front();
                    if (want.public_key !== out_data.public_key)
                        $display("%0t: public_key exp %h got %h", $time,
                                 want.public_key, out_data.public_key);
                    if (want.cipher_first !== out_data.cipher_first)
                        $display("%0t: cipher_first exp %h got %h", $time,
                                 want.cipher_first, out_data.cipher_first);
                    if (want.cipher_second !== out_data.cipher_second)
                        $display("%0t: cipher_second exp %h got %h", $time,
                                 want.cipher_second, out_data.cipher_second);
                    if (want.recovered_message !== out_data.recovered_message)
                        $display("%0t: recovered_message exp %h got %h", $time,
                                 want.recovered_message, out_data.recovered_message);
                    if (want.inverse_found !== out_data.inverse_found)
                        $display("%0t: inverse_found exp %b got %b", $time,
                                 want.inverse_found, out_data.inverse_found);
                    if (want !== out_data)
                        failed = 1'b1;
                end
            end
            if (idle_cycles >= WD_LIMIT)
            begin
                $display("elgamal_encrypt_decrypt_unit_tb NOT OK");
                $finish;
            end
        end
    end

    task automatic wait_drain();
        while (msg_q.size() > 0 || in_valid || result_q.size() > 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_MODULUS:   mod_r = val;
            REG_GENERATOR: gen_r = val;
            default:       key_r = val;
        endcase
    endtask

    task automatic set_keys(logic [31:0] p, logic [31:0] a, logic [31:0] d);
        wait_drain();
        write_reg(REG_MODULUS, p);
        write_reg(REG_GENERATOR, a);
        write_reg(REG_PRIV_KEY, d);
    endtask

    task automatic send(logic [31:0] m, logic [31:0] k);
        eg_in_t item;
        item.message = m;
        item.nonce = k;
        msg_q.push_back(item);
    endtask

    initial
    begin
        logic [31:0] p;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_MODULUS;
        cfg_data = '0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        in_ready_seen = 1'b0;
        out_taken = 1'b0;
        mod_r = 32'd3;
        gen_r = 32'd2;
        key_r = 32'd1;
        gaps_on = 1'b1;
        hold_send = 1'b0;
        failed = 1'b0;
        send_gap = 0;
        recv_gap = 0;
        idle_cycles = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings
        send(32'd0, 32'd1);
        send(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send(32'd2, 32'd5);
        // largest 32-bit prime, full-range operands
        set_keys(32'hFFFF_FFFB, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send(32'hFFFF_FFFA, 32'hFFFF_FFFF);
        send(32'hFFFF_FFFF, 32'd1);
        send(32'd1, 32'h8000_0000);
        // modulus not prime, all ones
        set_keys(32'hFFFF_FFFF, 32'd3, 32'd7);
        send(32'h1234_5678, 32'd9);
        send(32'hFFFF_FFFE, 32'h7FFF_FFFF);
        // modulus below two
        set_keys(32'd0, 32'd5, 32'd3);
        send(32'hDEAD_BEEF, 32'd4);
        set_keys(32'd1, 32'd5, 32'd3);
        send(32'd7, 32'd4);
        // smallest modulus that computes
        set_keys(32'd2, 32'd1, 32'd1);
        send(32'd1, 32'd1);
        send(32'd3, 32'd2);
        // generator a multiple of the modulus: shared secret zero
        set_keys(32'd97, 32'd194, 32'd11);
        send(32'd50, 32'd6);
        // shared factor with a composite modulus
        set_keys(32'd15, 32'd3, 32'd2);
        send(32'd4, 32'd3);
        send(32'd16, 32'd1);
        set_keys(32'd101, 32'd2, 32'd1);
        send(32'd100, 32'd1);
        send(32'd0, 32'd3);

        for (int ph = 0; ph < 9; ph++)
        begin
            case ($urandom_range(0, 3))
                0:       p = $urandom_range(3, 300);
                1:       p = $urandom_range(0, 2);
                default: p = $urandom | 32'h1;
            endcase
            set_keys(p, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20) : $urandom | 32'h1,
                     ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20) : $urandom | 32'h1);
            gaps_on = (ph % 3) != 2;
            if (ph == 4)
            begin
                hold_send = 1'b1;
                wait_drain();
                hold_send = 1'b0;
            end
            for (int i = 0; i < 10; i++)
                send((p > 1 && $urandom_range(0, 1)) ? $urandom % p : $urandom,
                     ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : $urandom | 32'h1);
            if (ph == 6)
            begin
                while (msg_q.size() > 5)
                    @(posedge clk);
                hold_send = 1'b1;
                while (result_q.size() > 0 || in_valid)
                    @(posedge clk);
                hold_send = 1'b0;
            end
        end

        wait_drain();
        repeat (50) @(posedge clk);
        if (!failed)
            $display("elgamal_encrypt_decrypt_unit_tb OK");
        else
            $display("elgamal_encrypt_decrypt_unit_tb NOT OK");
        $finish;
    end

endmodule

// File: filelist.f
rtl/eg_pkg.sv
rtl/eg_datapath.sv
rtl/eg_ctrl.sv
rtl/elgamal_encrypt_decrypt_unit.sv
verif/elgamal_encrypt_decrypt_unit_tb.sv
